[hdl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants and codes for the text console writer unit.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int KIND_W      = 1;
	localparam int CHAR_W      = 8;
	localparam int ADDR_W      = 11;
	localparam int POS_W       = 11;
	localparam int CELL_W      = 16;
	localparam int COLOUR_W    = 8;

	localparam logic [KIND_W-1:0]   KIND_PUT     = 1'b0;
	localparam logic [KIND_W-1:0]   KIND_READ    = 1'b1;
	localparam logic [CHAR_W-1:0]   NEWLINE_CHAR = 8'd10;
	localparam logic [CELL_W-1:0]   RESET_CELL   = 16'h0720;
	localparam logic [CELL_W-1:0]   BLANK_CELL   = 16'h0000;
	localparam logic [COLOUR_W-1:0] COLOUR_RESET = 8'd7;

endpackage

[hdl/tcw_if.sv]
// ----------------------------------------------------------------------------
// tcw_if
// Valid/ready channels for requests and responses of the console writer.
// ----------------------------------------------------------------------------
interface tcw_req_if;
	logic                          valid;
	logic                          ready;
	logic [tcw_pkg::KIND_W-1:0]    kind;
	logic [tcw_pkg::CHAR_W-1:0]    character;
	logic [tcw_pkg::ADDR_W-1:0]    cell_address;

	modport source (output valid, kind, character, cell_address, input ready);
	modport sink   (input valid, kind, character, cell_address, output ready);
endinterface

interface tcw_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [tcw_pkg::POS_W-1:0]     cursor_position;
	logic [tcw_pkg::CELL_W-1:0]    cell_data;
	logic                          scrolled;

	modport source (output valid, cursor_position, cell_data, scrolled, input ready);
	modport sink   (input valid, cursor_position, cell_data, scrolled, output ready);
endinterface

[hdl/text_console_writer_unit.sv]
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text screen with cursor, character writes, newline, scroll and cell reads.
// ----------------------------------------------------------------------------
// A read or a put without scroll goes through the done state and responds
// once the output register is free; a put that scrolls first copies the
// screen up a row, one cell per cycle, then blanks the bottom row. One item
// at a time. Reset: cursor to 0, colour to 7, then a clearing pass fills
// every cell with 0x0720; no request is taken during that pass.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tcw_pkg::COLOUR_W-1:0]  cfg_wdata,
	tcw_req_if.sink                       req,
	tcw_rsp_if.source                     rsp
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int PW    = (AW > tcw_pkg::ADDR_W) ? AW : tcw_pkg::ADDR_W;
	localparam int RW    = $clog2(ROWS + 1);
	localparam int CLW   = $clog2(COLUMNS);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCROLL = 3'd2;
	localparam logic [2:0] S_BOTTOM = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0]                       state_q;
	logic [AW-1:0]                    ptr_q;
	logic [RW-1:0]                    row_q;
	logic [CLW-1:0]                   col_q;
	logic [tcw_pkg::COLOUR_W-1:0]     colour_q;
	logic                             copy_valid_q;
	logic [AW-1:0]                    copy_addr_q;
	logic [tcw_pkg::KIND_W-1:0]       kind_q;
	logic                             range_q;
	logic                             scroll_q;
	logic [tcw_pkg::CELL_W-1:0]       rd_q;
	logic                             rsp_valid_q;
	logic [tcw_pkg::POS_W-1:0]        pos_q;
	logic [tcw_pkg::CELL_W-1:0]       data_q;
	logic                             scrolled_q;

	logic [tcw_pkg::CELL_W-1:0]       mem [CELLS];

	logic                             accept;
	logic                             is_put;
	logic                             is_nl;
	logic [RW-1:0]                    row_a;
	logic [RW-1:0]                    row_b;
	logic [RW-1:0]                    row_n;
	logic [CLW-1:0]                   col_n;
	logic [CLW:0]                     col_inc;
	logic                             need_scroll;
	logic [PW-1:0]                    cur_pos;
	logic [PW-1:0]                    rd_ext;
	logic                             rd_in_range;
	logic                             out_free;
	logic                             we;
	logic [AW-1:0]                    wa;
	logic [tcw_pkg::CELL_W-1:0]       wd;
	logic                             re;
	logic [AW-1:0]                    ra;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_put    = (req.kind == tcw_pkg::KIND_PUT);
	assign is_nl     = (req.character == tcw_pkg::NEWLINE_CHAR);
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign cur_pos     = PW'(row_q) * PW'(COLUMNS) + PW'(col_q);
	assign rd_ext      = PW'(req.cell_address);
	assign rd_in_range = rd_ext < PW'(CELLS);

	always_comb begin
		row_a       = is_nl ? row_q + RW'(1) : row_q;
		need_scroll = row_a >= RW'(ROWS - 1);
		row_b       = need_scroll ? row_a - RW'(1) : row_a;
		col_inc     = {1'b0, col_q} + (CLW + 1)'(1);
		if (is_nl) begin
			col_n = '0;
			row_n = row_b;
		end else if (col_inc == (CLW + 1)'(COLUMNS)) begin
			col_n = '0;
			row_n = row_b + RW'(1);
		end else begin
			col_n = col_inc[CLW-1:0];
			row_n = row_b;
		end
	end

	always_comb begin
		we = 1'b0;
		wa = ptr_q;
		wd = tcw_pkg::RESET_CELL;
		re = 1'b0;
		ra = ptr_q;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_IDLE: begin
				we = accept && is_put && !is_nl;
				wa = cur_pos[AW-1:0];
				wd = {colour_q, req.character};
				re = accept && !is_put;
				ra = rd_ext[AW-1:0];
			end
			S_SCROLL: begin
				we = copy_valid_q;
				wa = copy_addr_q;
				wd = rd_q;
				re = 1'b1;
			end
			S_BOTTOM: begin
				we = 1'b1;
				wa = copy_valid_q ? copy_addr_q : ptr_q;
				wd = copy_valid_q ? rd_q : tcw_pkg::BLANK_CELL;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_q <= tcw_pkg::COLOUR_RESET;
		end else if (cfg_we) begin
			colour_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			ptr_q        <= '0;
			row_q        <= '0;
			col_q        <= '0;
			copy_valid_q <= 1'b0;
			copy_addr_q  <= '0;
			kind_q       <= tcw_pkg::KIND_PUT;
			range_q      <= 1'b0;
			scroll_q     <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (ptr_q == AW'(CELLS - 1)) begin
						ptr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						kind_q       <= req.kind;
						range_q      <= rd_in_range;
						copy_valid_q <= 1'b0;
						if (is_put) begin
							row_q    <= row_n;
							col_q    <= col_n;
							scroll_q <= need_scroll;
							if (need_scroll) begin
								ptr_q   <= AW'(COLUMNS);
								state_q <= S_SCROLL;
							end else begin
								state_q <= S_DONE;
							end
						end else begin
							scroll_q <= 1'b0;
							state_q  <= S_DONE;
						end
					end
				end
				S_SCROLL: begin
					copy_valid_q <= 1'b1;
					copy_addr_q  <= ptr_q - AW'(COLUMNS);
					if (ptr_q == AW'(CELLS - 1)) begin
						ptr_q   <= AW'(CELLS - COLUMNS);
						state_q <= S_BOTTOM;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_BOTTOM: begin
					if (copy_valid_q) begin
						copy_valid_q <= 1'b0;
					end else if (ptr_q == AW'(CELLS - 1)) begin
						state_q <= S_DONE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			pos_q      <= cur_pos[tcw_pkg::POS_W-1:0];
			data_q     <= (kind_q == tcw_pkg::KIND_READ && range_q) ? rd_q
			              : tcw_pkg::BLANK_CELL;
			scrolled_q <= scroll_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.cursor_position = pos_q;
	assign rsp.cell_data       = data_q;
	assign rsp.scrolled        = scrolled_q;

endmodule

[hdl/tcw_checker.sv]
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer unit, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [tcw_pkg::POS_W-1:0]   rsp_cursor_position,
	input logic [tcw_pkg::CELL_W-1:0]  rsp_cell_data,
	input logic                        rsp_scrolled
);

	localparam int CELLS = COLUMNS * ROWS;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_position)
		&& $stable(rsp_cell_data) && $stable(rsp_scrolled))
		else $error("Stalled response changed.");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("Request taken while an item was in progress.");

	a_clear_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !req_ready)
		else $error("Request taken before the screen was cleared.");

	a_scroll_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_scrolled |-> rsp_cell_data == tcw_pkg::BLANK_CELL)
		else $error("Scrolling put returned cell data.");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (CELLS > 2048) || (32'(rsp_cursor_position) < 32'(CELLS)))
		else $error("Cursor position outside the screen.");

endmodule

bind text_console_writer_unit tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_cursor_position (rsp.cursor_position),
	.rsp_cell_data       (rsp.cell_data),
	.rsp_scrolled        (rsp.scrolled)
);

[sim/tb_text_console_writer_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_unit
// Self-checking bench for the text console writer. An initial block queues
// character puts and cell reads; a clocked driver sends them with random gaps,
// and a clocked monitor checks each response against a screen and cursor model
// that is updated on every request transfer. The text colour changes between
// phases, while no request is in flight.
// ----------------------------------------------------------------------------
module tb_text_console_writer_unit;

	localparam int SCREEN_COLUMNS = tcw_pkg::COLUMNS_DEF;
	localparam int SCREEN_ROWS    = tcw_pkg::ROWS_DEF;
	localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int CYCLE_LIMIT    = 8000000;

	typedef struct packed {
		logic [tcw_pkg::KIND_W-1:0] kind;
		logic [tcw_pkg::CHAR_W-1:0] character;
		logic [tcw_pkg::ADDR_W-1:0] cell_address;
	} console_item_t;

	typedef struct packed {
		logic [tcw_pkg::POS_W-1:0]  cursor_position;
		logic [tcw_pkg::CELL_W-1:0] cell_data;
		logic                       scrolled;
	} console_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we;
	logic [tcw_pkg::COLOUR_W-1:0] cfg_wdata;

	tcw_req_if req_ch ();
	tcw_rsp_if rsp_ch ();

	text_console_writer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	logic [tcw_pkg::CELL_W-1:0]   screen_model [CELL_COUNT];
	int unsigned                  row_model;
	int unsigned                  column_model;
	logic [tcw_pkg::COLOUR_W-1:0] colour_model;

	console_item_t   item_backlog [$];
	console_result_t result_log [$];
	int              items_queued = 0;
	int              items_accepted = 0;
	int              error_count = 0;
	int              cycle_count = 0;
	int              gap_left;
	int              send_quiet;
	int              stall_left;
	int              take_quiet;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic console_result_t console_step(input console_item_t item);
		console_result_t res;
		int unsigned     idx;
		logic            newline;
		res = '0;
		if (item.kind == tcw_pkg::KIND_READ) begin
			if (item.cell_address < CELL_COUNT)
				res.cell_data = screen_model[item.cell_address];
		end else begin
			newline = (item.character == tcw_pkg::NEWLINE_CHAR);
			if (newline)
				row_model++;
			else
				screen_model[row_model * SCREEN_COLUMNS + column_model] =
					{colour_model, item.character};
			if (row_model >= SCREEN_ROWS - 1) begin
				for (idx = 0; idx < CELL_COUNT - SCREEN_COLUMNS; idx++)
					screen_model[idx] = screen_model[idx + SCREEN_COLUMNS];
				for (idx = CELL_COUNT - SCREEN_COLUMNS; idx < CELL_COUNT; idx++)
					screen_model[idx] = tcw_pkg::BLANK_CELL;
				row_model--;
				res.scrolled = 1'b1;
			end
			if (newline) begin
				column_model = 0;
			end else begin
				column_model++;
				if (column_model >= SCREEN_COLUMNS) begin
					column_model = 0;
					row_model++;
				end
			end
		end
		res.cursor_position =
			(tcw_pkg::POS_W)'(row_model * SCREEN_COLUMNS + column_model);
		return res;
	endfunction

	function automatic int draw_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic push_item(input logic [tcw_pkg::KIND_W-1:0] kind,
		input logic [tcw_pkg::CHAR_W-1:0] character,
		input logic [tcw_pkg::ADDR_W-1:0] cell_address);
		console_item_t item;
		item.kind = kind;
		item.character = character;
		item.cell_address = cell_address;
		item_backlog.push_back(item);
		items_queued++;
	endtask

	task automatic queue_random_text(input int target);
		int made;
		int r;
		int len;
		int i;
		made = 0;
		while (made < target) begin
			r = $urandom_range(0, 99);
			if (r < 20) begin
				if ($urandom_range(0, 1) == 0)
					push_item(tcw_pkg::KIND_READ, (tcw_pkg::CHAR_W)'($urandom),
						(tcw_pkg::ADDR_W)'($urandom));
				else
					push_item(tcw_pkg::KIND_READ, (tcw_pkg::CHAR_W)'($urandom),
						(tcw_pkg::ADDR_W)'($urandom_range(
							CELL_COUNT - 3 * SCREEN_COLUMNS, CELL_COUNT - 1)));
				made++;
			end else if (r < 25) begin
				push_item(tcw_pkg::KIND_PUT, (tcw_pkg::CHAR_W)'($urandom),
					(tcw_pkg::ADDR_W)'($urandom));
				made++;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70)
					len = $urandom_range(0, 4);
				else if (r < 95)
					len = $urandom_range(5, 40);
				else
					len = $urandom_range(80, 170);
				for (i = 0; i < len; i++)
					push_item(tcw_pkg::KIND_PUT, (tcw_pkg::CHAR_W)'($urandom_range(0, 255)),
						(tcw_pkg::ADDR_W)'($urandom));
				push_item(tcw_pkg::KIND_PUT, tcw_pkg::NEWLINE_CHAR,
					(tcw_pkg::ADDR_W)'($urandom));
				made += len + 1;
			end
		end
	endtask

	task automatic write_colour(input logic [tcw_pkg::COLOUR_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		colour_model = value;
	endtask

	task automatic wait_for_drain();
		@(posedge clk);
		while (items_accepted != items_queued || result_log.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		int            gap;
		console_item_t sent;
		console_item_t next_item;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.kind <= tcw_pkg::KIND_PUT;
			req_ch.character <= '0;
			req_ch.cell_address <= '0;
			gap_left <= 0;
			send_quiet <= 0;
		end else if (!req_ch.valid || req_ch.ready) begin
			gap = gap_left;
			if (req_ch.valid) begin
				sent.kind = req_ch.kind;
				sent.character = req_ch.character;
				sent.cell_address = req_ch.cell_address;
				result_log.push_back(console_step(sent));
				items_accepted++;
				if (send_quiet > 0) begin
					gap = 0;
					send_quiet <= send_quiet - 1;
				end else begin
					gap = draw_idle();
					if ($urandom_range(0, 39) == 0)
						send_quiet <= 30;
				end
			end
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				gap_left <= gap - 1;
			end else if (item_backlog.size() > 0) begin
				next_item = item_backlog.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.kind <= next_item.kind;
				req_ch.character <= next_item.character;
				req_ch.cell_address <= next_item.cell_address;
				gap_left <= 0;
			end else begin
				req_ch.valid <= 1'b0;
				gap_left <= 0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		console_result_t want;
		int              stall;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= 0;
			take_quiet <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (result_log.size() == 0) begin
					$error("Unexpected response: cursor_position %0d cell_data %h scrolled %0b",
						rsp_ch.cursor_position, rsp_ch.cell_data, rsp_ch.scrolled);
					error_count++;
				end else begin
					want = result_log.pop_front();
					if (rsp_ch.cursor_position !== want.cursor_position) begin
						$error("cursor_position: expected %0d, got %0d",
							want.cursor_position, rsp_ch.cursor_position);
						error_count++;
					end
					if (rsp_ch.cell_data !== want.cell_data) begin
						$error("cell_data: expected %h, got %h", want.cell_data, rsp_ch.cell_data);
						error_count++;
					end
					if (rsp_ch.scrolled !== want.scrolled) begin
						$error("scrolled: expected %0b, got %0b", want.scrolled, rsp_ch.scrolled);
						error_count++;
					end
				end
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (take_quiet > 0) begin
				rsp_ch.ready <= 1'b1;
				take_quiet <= take_quiet - 1;
			end else if ($urandom_range(0, 3) == 0) begin
				stall = draw_idle();
				if (stall > 0) begin
					rsp_ch.ready <= 1'b0;
					stall_left <= stall - 1;
				end else begin
					rsp_ch.ready <= 1'b1;
					if ($urandom_range(0, 29) == 0)
						take_quiet <= 40;
				end
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int i;
		req_ch.valid = 1'b0;
		req_ch.kind = tcw_pkg::KIND_PUT;
		req_ch.character = '0;
		req_ch.cell_address = '0;
		rsp_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		for (i = 0; i < CELL_COUNT; i++)
			screen_model[i] = tcw_pkg::RESET_CELL;
		row_model = 0;
		column_model = 0;
		colour_model = tcw_pkg::COLOUR_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset contents, reads past the end of the screen, character extremes
		// in a black attribute, and newlines that leave blank rows behind.
		write_colour(8'h00);
		push_item(tcw_pkg::KIND_READ, 8'hFF, (tcw_pkg::ADDR_W)'(0));
		push_item(tcw_pkg::KIND_READ, 8'h00, (tcw_pkg::ADDR_W)'(CELL_COUNT - 1));
		push_item(tcw_pkg::KIND_READ, 8'h00, (tcw_pkg::ADDR_W)'(CELL_COUNT));
		push_item(tcw_pkg::KIND_READ, 8'h00, '1);
		push_item(tcw_pkg::KIND_PUT, 8'h00, '1);
		push_item(tcw_pkg::KIND_PUT, 8'hFF, '0);
		push_item(tcw_pkg::KIND_PUT, 8'h41, (tcw_pkg::ADDR_W)'(5));
		push_item(tcw_pkg::KIND_READ, 8'h00, (tcw_pkg::ADDR_W)'(0));
		push_item(tcw_pkg::KIND_READ, 8'h00, (tcw_pkg::ADDR_W)'(1));
		push_item(tcw_pkg::KIND_READ, 8'h00, (tcw_pkg::ADDR_W)'(2));
		push_item(tcw_pkg::KIND_PUT, tcw_pkg::NEWLINE_CHAR, '0);
		push_item(tcw_pkg::KIND_PUT, 8'h7E, '0);
		push_item(tcw_pkg::KIND_READ, 8'h00, (tcw_pkg::ADDR_W)'(SCREEN_COLUMNS));
		push_item(tcw_pkg::KIND_PUT, tcw_pkg::NEWLINE_CHAR, '0);
		push_item(tcw_pkg::KIND_PUT, tcw_pkg::NEWLINE_CHAR, '0);
		push_item(tcw_pkg::KIND_READ, 8'h00, (tcw_pkg::ADDR_W)'(2 * SCREEN_COLUMNS));
		wait_for_drain();

		write_colour(8'hFF);
		queue_random_text(220);
		wait_for_drain();

		write_colour((tcw_pkg::COLOUR_W)'($urandom_range(1, 254)));
		queue_random_text(210);
		wait_for_drain();

		write_colour(tcw_pkg::COLOUR_RESET);
		queue_random_text(200);
		wait_for_drain();

		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[filelist.f]
hdl/tcw_pkg.sv
hdl/tcw_if.sv
hdl/text_console_writer_unit.sv
hdl/tcw_checker.sv
sim/tb_text_console_writer_unit.sv
